/* rtl/mrect_pkg.sv */
// Shared types and constants for the maximal all-ones rectangle block.
// No dependencies; imported by the controller, the area unit, the top level and the testbench.
package mrect_pkg;

    localparam int AREA_W = 13;
    localparam logic [AREA_W-1:0] AREA_MAX = 13'd8191;

    localparam int RW_W = 7;
    localparam logic [RW_W-1:0] RW_RESET = 7'd64;

    localparam int ADDR_W = 3;
    localparam logic REG_ROW_WIDTH = 1'b0;

    typedef struct packed {
        logic take;
        logic clear;
    } unit_ctrl_t;

endpackage

/* rtl/mrect_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrect_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mrect_area_unit.sv */
// Shared area unit: one registered multiply, then saturate and keep the maximum.
// Depends on mrect_pkg.
module mrect_area_unit
    import mrect_pkg::*;
#(
    parameter int HW = 7,
    parameter int CW = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  unit_ctrl_t        ctl,
    input  logic [HW-1:0]     h,
    input  logic [CW-1:0]     w,
    output logic [AREA_W-1:0] best
);

    localparam int PW = HW + CW;
    localparam int SW = (PW > AREA_W) ? PW : AREA_W + 1;

    logic [PW-1:0]     prod_reg;
    logic              pv_reg;
    logic [AREA_W-1:0] best_reg;
    logic [SW-1:0]     prod_ext;
    logic [AREA_W-1:0] prod_sat;

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(h) * PW'(w);
    end

    assign prod_ext = SW'(prod_reg);
    assign prod_sat = (prod_ext > SW'(AREA_MAX)) ? AREA_MAX : prod_ext[AREA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg   <= 1'b0;
            best_reg <= '0;
        end
        else if (ctl.clear)
        begin
            pv_reg   <= 1'b0;
            best_reg <= '0;
        end
        else
        begin
            pv_reg <= ctl.take;
            if (pv_reg && (prod_sat > best_reg))
            begin
                best_reg <= prod_sat;
            end
        end
    end

    assign best = best_reg;

endmodule

/* rtl/mrect_ctrl.sv */
// Sequencer: column height update and monotonic-stack histogram pass.
// Depends on mrect_pkg and mrect_ram (height store and stack store).
module mrect_ctrl
    import mrect_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    parameter int HW = 7,
    parameter int CW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          cell_req,
    input  logic          last_in_matrix,
    input  logic [CW-1:0] width,
    output logic          busy,
    output unit_ctrl_t    ctl,
    output logic [HW-1:0] mul_h,
    output logic [CW-1:0] mul_w,
    output logic          fin
);

    localparam int IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SEW = IW + HW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UPD   = 4'd1;
    localparam logic [3:0] S_PRD   = 4'd2;
    localparam logic [3:0] S_LOOP  = 4'd3;
    localparam logic [3:0] S_POPW  = 4'd4;
    localparam logic [3:0] S_FLUSH = 4'd5;
    localparam logic [3:0] S_FPOPW = 4'd6;
    localparam logic [3:0] S_WAIT  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [IW-1:0]       col_reg, col_next;
    logic                cell_reg, cell_next;
    logic                last_reg, last_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       cols_reg, cols_next;
    logic [IW-1:0]       pl_reg, pl_next;
    logic [CW-1:0]       depth_reg, depth_next;
    logic [HW-1:0]       top_h_reg, top_h_next;
    logic [IW-1:0]       top_l_reg, top_l_next;
    logic [MAX_COLS-1:0] hv_reg;
    logic                hv_rd_reg;

    logic                h_we, h_re;
    logic [IW-1:0]       h_raddr;
    logic [HW-1:0]       h_wdata, h_rdata;
    logic                s_we, s_re;
    logic [IW-1:0]       s_waddr, s_raddr;
    logic [SEW-1:0]      s_rdata;

    logic [HW-1:0]       hc;
    logic [CW-1:0]       col_inc;
    logic [CW-1:0]       i_inc;
    logic [CW-1:0]       depth_dec;
    logic [CW-1:0]       depth_dec2;

    mrect_ram #(.WIDTH(HW), .DEPTH(MAX_COLS)) u_hmem (
        .clk   (clk),
        .we    (h_we),
        .waddr (col_reg),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    mrect_ram #(.WIDTH(SEW), .DEPTH(MAX_COLS)) u_smem (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata ({top_l_reg, top_h_reg}),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // unwritten columns read as zero height
    assign hc         = hv_rd_reg ? h_rdata : '0;
    assign col_inc    = CW'(col_reg) + CW'(1);
    assign i_inc      = i_reg + CW'(1);
    assign depth_dec  = depth_reg - CW'(1);
    assign depth_dec2 = depth_reg - CW'(2);

    always_comb
    begin
        if (!cell_reg)
        begin
            h_wdata = '0;
        end
        else if (HW'(hc) < HW'(MAX_ROWS))
        begin
            h_wdata = hc + HW'(1);
        end
        else
        begin
            h_wdata = hc;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        cell_next  = cell_reg;
        last_next  = last_reg;
        i_next     = i_reg;
        cols_next  = cols_reg;
        pl_next    = pl_reg;
        depth_next = depth_reg;
        top_h_next = top_h_reg;
        top_l_next = top_l_reg;
        h_we       = 1'b0;
        h_re       = 1'b0;
        h_raddr    = col_reg;
        s_we       = 1'b0;
        s_re       = 1'b0;
        s_waddr    = depth_dec[IW-1:0];
        s_raddr    = depth_dec2[IW-1:0];
        ctl.take   = 1'b0;
        ctl.clear  = 1'b0;
        mul_h      = top_h_reg;
        mul_w      = '0;
        fin        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cell_next  = cell_req;
                    last_next  = last_in_matrix;
                    h_re       = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                h_we = 1'b1;
                if ((col_inc >= width) || last_reg)
                begin
                    cols_next  = col_inc;
                    i_next     = '0;
                    depth_next = '0;
                    col_next   = '0;
                    state_next = S_PRD;
                end
                else
                begin
                    col_next   = col_inc[IW-1:0];
                    state_next = S_IDLE;
                end
            end
            S_PRD:
            begin
                h_re       = 1'b1;
                h_raddr    = i_reg[IW-1:0];
                pl_next    = i_reg[IW-1:0];
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if ((depth_reg != '0) && (top_h_reg >= hc))
                begin
                    // pop: bar spans from its left bound up to column i
                    ctl.take   = 1'b1;
                    mul_w      = i_reg - CW'(top_l_reg);
                    pl_next    = top_l_reg;
                    depth_next = depth_dec;
                    if (depth_reg >= CW'(2))
                    begin
                        s_re       = 1'b1;
                        state_next = S_POPW;
                    end
                end
                else
                begin
                    if (depth_reg != '0)
                    begin
                        s_we = 1'b1;
                    end
                    top_h_next = hc;
                    top_l_next = pl_reg;
                    depth_next = depth_reg + CW'(1);
                    if (i_inc < cols_reg)
                    begin
                        i_next  = i_inc;
                        h_re    = 1'b1;
                        h_raddr = i_inc[IW-1:0];
                        pl_next = i_inc[IW-1:0];
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_POPW:
            begin
                top_h_next = s_rdata[HW-1:0];
                top_l_next = s_rdata[SEW-1:HW];
                state_next = S_LOOP;
            end
            S_FLUSH:
            begin
                ctl.take   = 1'b1;
                mul_w      = cols_reg - CW'(top_l_reg);
                depth_next = depth_dec;
                if (depth_reg >= CW'(2))
                begin
                    s_re       = 1'b1;
                    state_next = S_FPOPW;
                end
                else if (last_reg)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FPOPW:
            begin
                top_h_next = s_rdata[HW-1:0];
                top_l_next = s_rdata[SEW-1:HW];
                state_next = S_FLUSH;
            end
            S_WAIT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                fin        = 1'b1;
                ctl.clear  = 1'b1;
                col_next   = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            depth_reg <= '0;
            hv_reg    <= '0;
            hv_rd_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            depth_reg <= depth_next;
            if (fin)
            begin
                hv_reg <= '0;
            end
            else if (h_we)
            begin
                hv_reg[col_reg] <= 1'b1;
            end
            if (h_re)
            begin
                hv_rd_reg <= hv_reg[h_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg  <= cell_next;
        last_reg  <= last_next;
        i_reg     <= i_next;
        cols_reg  <= cols_next;
        pl_reg    <= pl_next;
        top_h_reg <= top_h_next;
        top_l_reg <= top_l_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* rtl/max_rectangle_of_ones_core.sv */
// Largest all-ones rectangle over a streamed binary matrix, one cell per transfer.
// A cell that does not end a row updates its column height; a row-ending cell adds a
// stack pass over the row's columns (push, pop, stack reload through one RAM port),
// and the final cell then delivers max_area. done pulses one cycle; the
// receiver cannot stall. Async active-low reset: heights and best area zero, row_width 64.
// Depends on mrect_pkg, mrect_ctrl, mrect_area_unit, mrect_ram.
module max_rectangle_of_ones_core
    import mrect_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic              cell_req,
    input  logic              last_in_matrix,
    output logic              done,
    output logic [AREA_W-1:0] max_area
);

    localparam int HW = $clog2(MAX_ROWS + 1);
    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int EW = (CW > RW_W) ? CW : RW_W;

    logic [RW_W-1:0]   row_width_reg;
    logic [EW-1:0]     rw_ext;
    logic [CW-1:0]     width_eff;
    unit_ctrl_t        ctl;
    logic [HW-1:0]     mul_h;
    logic [CW-1:0]     mul_w;
    logic              fin;
    logic [AREA_W-1:0] best;
    logic              done_reg;
    logic [AREA_W-1:0] area_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= RW_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_ROW_WIDTH))
        begin
            row_width_reg <= pwdata[RW_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ROW_WIDTH) ? 32'(row_width_reg) : 32'd0;

    // zero width acts as one column, oversize clamps to the column store
    assign rw_ext = EW'(row_width_reg);
    always_comb
    begin
        priority if (rw_ext == '0)
        begin
            width_eff = CW'(1);
        end
        else if (rw_ext > EW'(MAX_COLS))
        begin
            width_eff = CW'(MAX_COLS);
        end
        else
        begin
            width_eff = rw_ext[CW-1:0];
        end
    end

    mrect_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .HW       (HW),
        .CW       (CW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .cell_req       (cell_req),
        .last_in_matrix (last_in_matrix),
        .width          (width_eff),
        .busy           (busy),
        .ctl            (ctl),
        .mul_h          (mul_h),
        .mul_w          (mul_w),
        .fin            (fin)
    );

    mrect_area_unit #(
        .HW (HW),
        .CW (CW)
    ) u_area (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .h     (mul_h),
        .w     (mul_w),
        .best  (best)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            area_reg <= best;
        end
    end

    assign done     = done_reg;
    assign max_area = area_reg;

endmodule

/* sim/max_rectangle_of_ones_core_test.sv */
// Self-checking testbench for max_rectangle_of_ones_core: streams binary matrices
// cell by cell and checks each reported area against a built-in histogram predictor.
// Depends on mrect_pkg and the max_rectangle_of_ones_core RTL.
`timescale 1ns / 1ps

module max_rectangle_of_ones_core_test;
    import mrect_pkg::*;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    // longest row pass plus delivery, with margin
    localparam int SETTLE_CYCLES = 3 * MAX_COLS + 64;
    localparam int CELL_TARGET = 1350;
    localparam int AREA_TARGET = 60;

    typedef struct {
        logic bit_val;
        logic fin;
    } cell_xfer_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              start = 1'b0;
    logic              busy;
    logic              cell_req = 1'b0;
    logic              last_in_matrix = 1'b0;
    logic              done;
    logic [AREA_W-1:0] max_area;

    max_rectangle_of_ones_core #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .start(start),
        .busy(busy),
        .cell_req(cell_req),
        .last_in_matrix(last_in_matrix),
        .done(done),
        .max_area(max_area)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    cell_xfer_t        pending_cells[$];
    logic [AREA_W-1:0] expected_areas[$];
    int unsigned       mismatch_count = 0;
    int unsigned       send_gap_pct = 0;
    int unsigned       cells_queued = 0;
    int unsigned       finals_queued = 0;

    // Mirror of the block's state
    logic [RW_W-1:0]   width_cfg = RW_RESET;
    int unsigned       col_height[MAX_COLS];
    int unsigned       cur_col = 0;
    int unsigned       best_so_far = 0;

    function automatic int unsigned active_width();
        if (width_cfg == 0)
            return 1;
        if (width_cfg > MAX_COLS)
            return MAX_COLS;
        return width_cfg;
    endfunction

    // Largest rectangle in the histogram of columns 0..cols-1; a zero bar past
    // the end flushes the stack.
    function automatic void scan_row(int unsigned cols);
        int unsigned stk[MAX_COLS + 1];
        int unsigned left_edge[MAX_COLS + 1];
        int unsigned depth;
        int unsigned h;
        int unsigned top;
        int unsigned area;
        depth = 0;
        for (int unsigned i = 0; i <= cols; i++)
        begin
            h = (i < cols) ? col_height[i] : 0;
            while (depth > 0 && (col_height[stk[depth-1]] >= h || i == cols))
            begin
                top = stk[depth-1];
                depth--;
                area = col_height[top] * (i - left_edge[top]);
                if (area > AREA_MAX)
                    area = AREA_MAX;
                if (area > best_so_far)
                    best_so_far = area;
            end
            if (i < cols)
            begin
                left_edge[i] = (depth == 0) ? 0 : stk[depth-1] + 1;
                stk[depth] = i;
                depth++;
            end
        end
    endfunction

    function automatic void predict_cell(logic bit_val, logic fin);
        int unsigned w;
        int unsigned col;
        w = active_width();
        col = (cur_col >= MAX_COLS) ? MAX_COLS - 1 : cur_col;
        if (bit_val)
        begin
            if (col_height[col] < MAX_ROWS)
                col_height[col]++;
        end
        else
            col_height[col] = 0;
        if (col + 1 >= w || fin)
        begin
            scan_row(col + 1);
            cur_col = 0;
        end
        else
            cur_col = col + 1;
        if (fin)
        begin
            expected_areas.push_back(AREA_W'(best_so_far));
            foreach (col_height[i])
                col_height[i] = 0;
            best_so_far = 0;
            cur_col = 0;
        end
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("tb: mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Driver: hold an item until accepted, then take the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cell_req <= 1'b0;
            last_in_matrix <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_cell(pending_cells[0].bit_val, pending_cells[0].fin);
                pending_cells.delete(0);
            end
            if (start && busy)
            begin
                start <= 1'b1;
            end
            else if (pending_cells.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                start <= 1'b1;
                cell_req <= pending_cells[0].bit_val;
                last_in_matrix <= pending_cells[0].fin;
            end
            else
            begin
                start <= 1'b0;
                cell_req <= 1'($urandom_range(1));
                last_in_matrix <= 1'($urandom_range(1));
            end
        end
    end

    // Monitor: each done strobe carries one area transfer
    always @(posedge clk)
    begin
        logic [AREA_W-1:0] want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_areas.size() == 0)
                report_mismatch("area with no matrix pending", max_area, 0);
            else
            begin
                want = expected_areas.pop_front();
                if (max_area !== want)
                    report_mismatch("max_area", max_area, want);
            end
        end
    end

    task automatic write_row_width(logic [RW_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * REG_ROW_WIDTH);
        pwdata <= {25'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        width_cfg = value;
    endtask

    task automatic wait_drained();
        while (pending_cells.size() != 0 || expected_areas.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_cell(logic bit_val, logic fin);
        pending_cells.push_back('{bit_val: bit_val, fin: fin});
        cells_queued++;
        if (fin)
            finals_queued++;
    endtask

    // Queue one matrix at the current width; returns the number of cells queued
    task automatic queue_matrix(output int unsigned n_cells);
        int unsigned w;
        int unsigned rows;
        int unsigned density;
        int unsigned kind;
        int unsigned cut;
        w = active_width();
        kind = $urandom_range(99);
        case ($urandom_range(3))
            0: density = 0;
            1: density = 50;
            2: density = 85;
            default: density = 100;
        endcase
        n_cells = 0;
        if (kind < 8 && w <= 4)
        begin
            // tall columns to reach height saturation
            rows = $urandom_range(MAX_ROWS + 1, MAX_ROWS + 6);
            density = 97;
        end
        else
        begin
            rows = $urandom_range(1, (256 / w > 8) ? 8 : ((256 / w < 1) ? 1 : 256 / w));
            if (rows > 4 && w > 32)
                rows = 4;
        end
        if (kind >= 90)
        begin
            // noise: random cells, a matrix end only now and then
            cut = $urandom_range(1, 2 * w);
            for (int unsigned i = 0; i < cut; i++)
                add_cell(1'($urandom_range(1)), $urandom_range(99) < 4);
            n_cells = cut;
        end
        else
        begin
            // early end: stop somewhere inside the final row
            cut = (kind >= 75) ? $urandom_range(1, w) : w;
            for (int unsigned r = 0; r < rows; r++)
                for (int unsigned c = 0; c < ((r == rows - 1) ? cut : w); c++)
                    add_cell($urandom_range(99) < density,
                             r == rows - 1 && c == ((r == rows - 1) ? cut : w) - 1);
            n_cells = (rows - 1) * w + cut;
        end
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned phase_cells;
        int unsigned n;
        logic [RW_W-1:0] w_next;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single-cell matrices at the reset width
        add_cell(1'b1, 1'b1);
        add_cell(1'b0, 1'b1);
        wait_idle();
        // width zero acts as one column
        write_row_width(7'd0);
        repeat (3) add_cell(1'b1, 1'b0);
        add_cell(1'b1, 1'b1);
        wait_idle();
        // width above the column count, matrix ends mid-row
        write_row_width(7'd127);
        add_cell(1'b1, 1'b0);
        add_cell(1'b1, 1'b0);
        add_cell(1'b0, 1'b0);
        add_cell(1'b1, 1'b0);
        add_cell(1'b1, 1'b1);
        wait_idle();
        write_row_width(7'd3);
        repeat (5) add_cell(1'b1, 1'b0);
        add_cell(1'b1, 1'b1);
        wait_idle();
        // shrink the width while a row is open
        write_row_width(7'd5);
        repeat (4) add_cell(1'b1, 1'b0);
        wait_idle();
        write_row_width(7'd2);
        add_cell(1'b1, 1'b0);
        add_cell(1'b1, 1'b1);
        wait_idle();

        phase = 0;
        while (cells_queued < CELL_TARGET || finals_queued < AREA_TARGET)
        begin
            case (phase)
                0: w_next = 7'd1;
                1: w_next = 7'd64;
                2: w_next = 7'd0;
                3: w_next = 7'd127;
                default:
                    case ($urandom_range(9))
                        0: w_next = 7'd1;
                        1: w_next = 7'd64;
                        2: w_next = 7'($urandom_range(65, 127));
                        3, 4: w_next = 7'($urandom_range(1, 64));
                        default: w_next = 7'($urandom_range(2, 12));
                    endcase
            endcase
            write_row_width(w_next);
            case (phase % 4)
                0: send_gap_pct = 0;
                1: send_gap_pct = 61;
                2: send_gap_pct = 0;
                default: send_gap_pct = 20;
            endcase
            phase_cells = 0;
            while (phase_cells < 150)
            begin
                queue_matrix(n);
                phase_cells += n;
                // hold off the next matrix until its area has come back
                if (phase == 2)
                    wait_drained();
            end
            wait_idle();
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* max_rectangle_of_ones_core.f */
rtl/mrect_pkg.sv
rtl/mrect_ram.sv
rtl/mrect_area_unit.sv
rtl/mrect_ctrl.sv
rtl/max_rectangle_of_ones_core.sv
sim/max_rectangle_of_ones_core_test.sv
